FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the address text parser.
// Defining SYNTH turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

FILE: hdl/ipp_pkg.sv
// Package for the IPv4/IPv6 address text parser.
// Holds character codes, group limits and the parse state type; no dependencies.
`default_nettype none

package ipp_pkg;

    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK  = 8'h5D;

    localparam int unsigned V4_GROUPS     = 4;
    localparam int unsigned V6_GROUPS     = 8;
    localparam int unsigned V6_MAX_DIGITS = 4;
    localparam logic [8:0]  V4_MAX        = 9'd255;
    localparam logic [8:0]  V4_SAT        = 9'd256;

    localparam logic [1:0] V4_LAST_INDEX  = 2'(V4_GROUPS - 1);
    localparam logic [2:0] V6_LAST_INDEX  = 3'(V6_GROUPS - 1);
    localparam logic [2:0] V6_DIGIT_LIMIT = 3'(V6_MAX_DIGITS);

    typedef struct packed {
        logic        seen_dot;
        logic        at_start;
        logic        v4_ok;
        logic [1:0]  v4_group_index;
        logic [8:0]  v4_group_value;
        logic        v4_group_started;
        logic [23:0] v4_address;
        logic        v6_ok;
        logic        v6_bracketed;
        logic        v6_closed;
        logic [2:0]  v6_group_index;
        logic [2:0]  v6_digit_count;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        seen_dot:         1'b0,
        at_start:         1'b1,
        v4_ok:            1'b1,
        v4_group_index:   2'd0,
        v4_group_value:   9'd0,
        v4_group_started: 1'b0,
        v4_address:       24'd0,
        v6_ok:            1'b1,
        v6_bracketed:     1'b0,
        v6_closed:        1'b0,
        v6_group_index:   3'd0,
        v6_digit_count:   3'd0
    };

    // Returns {is_hex, value} for one ASCII character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ip_address_text_parser.sv
// Top level of the IPv4/IPv6 address text parser.
// Uses ipp_pkg and assert_macros.svh.
//
// The parser takes one ASCII character per transaction on the s_ side, with
// s_tlast on the final character of the string, and returns one result
// transaction on the m_ side per string. It accepts one character every clock
// cycle unless a final character is held; each character is registered in the
// input register, where the IPv4 and IPv6 checks update in a single pass, and
// the result of the final character is registered in the output register, from
// which it is offered. Only a final character waits in the input register,
// blocking further input, while an untaken result occupies the output register.
`default_nettype none
`include "assert_macros.svh"

module ip_address_text_parser
    import ipp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] char_code
    input  wire logic         s_tlast,   // last_char
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // [63:0] address_high, [127:64] address_low
    output logic [1:0]        m_tuser    // [0] valid_res, [1] is_ipv6
);

    logic         in_valid_reg;
    logic [7:0]   in_char_reg;
    logic         in_last_reg;

    parse_state_t st_reg, st_next, st_upd;
    logic [15:0]  groups_reg [V6_GROUPS];
    logic [15:0]  groups_next [V6_GROUPS];
    logic [15:0]  groups_upd [V6_GROUPS];

    logic         m_valid_reg;
    logic         m_valid_next;
    logic [127:0] m_data_reg;
    logic [1:0]   m_user_reg;

    logic         out_free;
    logic         proc_fire;
    logic         res_fire;
    logic [4:0]   hex;
    logic [11:0]  v4_acc;
    logic         v4_res_ok;
    logic         v6_res_ok;
    logic [63:0]  res_high;
    logic [63:0]  res_low;
    logic         res_valid;

    assign out_free  = !m_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign res_fire  = proc_fire && in_last_reg;
    assign s_tready  = !in_valid_reg || proc_fire;

    assign hex    = hex_digit(in_char_reg);
    assign v4_acc = {st_reg.v4_group_value, 3'b000} + {2'b00, st_reg.v4_group_value, 1'b0}
                  + {4'd0, in_char_reg - 8'h30};

    always_comb begin
        st_upd = st_reg;
        for (int k = 0; k < V6_GROUPS; k++) begin
            groups_upd[k] = groups_reg[k];
        end

        if (in_char_reg == CHAR_DOT) begin
            st_upd.seen_dot = 1'b1;
        end
        st_upd.at_start = 1'b0;

        if (in_char_reg >= 8'h30 && in_char_reg <= 8'h39) begin
            st_upd.v4_group_value   = (v4_acc > {3'd0, V4_MAX}) ? V4_SAT : v4_acc[8:0];
            st_upd.v4_group_started = 1'b1;
        end else if (in_char_reg == CHAR_DOT) begin
            if (!st_reg.v4_group_started || st_reg.v4_group_index == V4_LAST_INDEX ||
                st_reg.v4_group_value > V4_MAX) begin
                st_upd.v4_ok = 1'b0;
            end else begin
                st_upd.v4_address       = {st_reg.v4_address[15:0],
                                           st_reg.v4_group_value[7:0]};
                st_upd.v4_group_index   = st_reg.v4_group_index + 2'd1;
                st_upd.v4_group_value   = 9'd0;
                st_upd.v4_group_started = 1'b0;
            end
        end else begin
            st_upd.v4_ok = 1'b0;
        end

        if (st_reg.v6_closed) begin
            st_upd.v6_ok = 1'b0;
        end else if (st_reg.at_start && in_char_reg == CHAR_LBRACK) begin
            st_upd.v6_bracketed = 1'b1;
        end else if (hex[4]) begin
            if (st_reg.v6_digit_count >= V6_DIGIT_LIMIT) begin
                st_upd.v6_ok = 1'b0;
            end else begin
                for (int k = 0; k < V6_GROUPS; k++) begin
                    if (st_reg.v6_group_index == 3'(k)) begin
                        groups_upd[k] = {groups_reg[k][11:0], hex[3:0]};
                    end
                end
                st_upd.v6_digit_count = st_reg.v6_digit_count + 3'd1;
            end
        end else if (in_char_reg == CHAR_COLON) begin
            if (st_reg.v6_group_index == V6_LAST_INDEX) begin
                st_upd.v6_ok = 1'b0;
            end else begin
                st_upd.v6_group_index = st_reg.v6_group_index + 3'd1;
                st_upd.v6_digit_count = 3'd0;
            end
        end else if (in_char_reg == CHAR_RBRACK) begin
            if (st_reg.v6_bracketed && st_reg.v6_group_index == V6_LAST_INDEX) begin
                st_upd.v6_closed = 1'b1;
            end else begin
                st_upd.v6_ok = 1'b0;
            end
        end else begin
            st_upd.v6_ok = 1'b0;
        end
    end

    always_comb begin
        v4_res_ok = st_upd.v4_ok && st_upd.v4_group_index == V4_LAST_INDEX &&
                    st_upd.v4_group_started && st_upd.v4_group_value <= V4_MAX;
        v6_res_ok = st_upd.v6_ok && st_upd.v6_group_index == V6_LAST_INDEX &&
                    (st_upd.v6_bracketed ? st_upd.v6_closed
                                         : (st_upd.v6_digit_count != 3'd0));
        res_high = 64'd0;
        res_low  = 64'd0;
        if (st_upd.seen_dot) begin
            res_valid = v4_res_ok;
            if (v4_res_ok) begin
                res_low = {32'd0, st_upd.v4_address, st_upd.v4_group_value[7:0]};
            end
        end else begin
            res_valid = v6_res_ok;
            if (v6_res_ok) begin
                res_high = {groups_upd[0], groups_upd[1], groups_upd[2], groups_upd[3]};
                res_low  = {groups_upd[4], groups_upd[5], groups_upd[6], groups_upd[7]};
            end
        end
    end

    always_comb begin
        st_next = st_reg;
        for (int k = 0; k < V6_GROUPS; k++) begin
            groups_next[k] = groups_reg[k];
        end
        if (proc_fire) begin
            if (in_last_reg) begin
                st_next = PARSE_RESET;
                for (int k = 0; k < V6_GROUPS; k++) begin
                    groups_next[k] = 16'd0;
                end
            end else begin
                st_next = st_upd;
                for (int k = 0; k < V6_GROUPS; k++) begin
                    groups_next[k] = groups_upd[k];
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            st_reg       <= PARSE_RESET;
            for (int k = 0; k < V6_GROUPS; k++) begin
                groups_reg[k] <= 16'd0;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            m_valid_reg <= m_valid_next;
            st_reg      <= st_next;
            for (int k = 0; k < V6_GROUPS; k++) begin
                groups_reg[k] <= groups_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (res_fire) begin
            m_data_reg <= {res_low, res_high};
            m_user_reg <= {!st_upd.seen_dot, res_valid};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `ASSERT_CLK(a_fail_zero, aclk, aresetn,
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 128'd0))
    `ASSERT_CLK(a_v4_high_zero, aclk, aresetn,
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[127:96] == 32'd0 && m_tdata[63:0] == 64'd0))
    `ASSERT_CLK(a_last_waits, aclk, aresetn,
        (in_valid_reg && in_last_reg && m_valid_reg && !m_tready) |=> in_valid_reg)
    `ASSERT_NEVER(a_result_overwrite, aclk, aresetn,
        res_fire && m_valid_reg && !m_tready)

endmodule

`default_nettype wire

FILE: dv/ipp_result_checker.sv
// Result checker for ip_address_text_parser: follows every accepted character,
// predicts the result of each string and compares it with each result transaction.
// Depends on ipp_pkg for the character codes and group limits.
module ipp_result_checker
    import ipp_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [7:0]   s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [127:0] m_tdata,
    input  wire logic [1:0]   m_tuser,
    output int                mismatches,
    output int                results_pending,
    output int                chars_checked,
    output int                ok_v4,
    output int                ok_v6,
    output int                bad_lines
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        addr_ok;
        logic        ipv6;
        logic [63:0] upper;
        logic [63:0] lower;
    } parse_result_t;

    logic        dot_found;
    logic        first_char;
    logic        dec_ok;
    logic [2:0]  dec_index;
    logic [8:0]  dec_value;
    logic        dec_started;
    logic [31:0] dec_address;
    logic        hex_ok;
    logic        hex_bracketed;
    logic        hex_closed;
    logic [3:0]  hex_index;
    logic [2:0]  hex_digits;
    logic [15:0] hex_groups [V6_GROUPS];

    parse_result_t expected_results[$];
    int            error_count = 0;
    int            char_count = 0;
    int            v4_count = 0;
    int            v6_count = 0;
    int            bad_count = 0;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    task automatic clear_parse();
        dot_found     = 1'b0;
        first_char    = 1'b1;
        dec_ok        = 1'b1;
        dec_index     = '0;
        dec_value     = '0;
        dec_started   = 1'b0;
        dec_address   = '0;
        hex_ok        = 1'b1;
        hex_bracketed = 1'b0;
        hex_closed    = 1'b0;
        hex_index     = '0;
        hex_digits    = '0;
        for (int g = 0; g < V6_GROUPS; g++) begin
            hex_groups[g] = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic absorb_char(input logic [7:0] c, input logic final_char);
        logic [12:0]   acc;
        int            nib;
        parse_result_t r;
        char_count++;
        if (c == CHAR_DOT) dot_found = 1'b1;

        if (c >= "0" && c <= "9") begin
            acc = 13'(dec_value) * 13'd10 + 13'(c - "0");
            dec_value = (acc > 13'(V4_MAX)) ? V4_SAT : acc[8:0];
            dec_started = 1'b1;
        end else if (c == CHAR_DOT) begin
            if (!dec_started || dec_index >= V4_GROUPS - 1 || dec_value > V4_MAX) begin
                dec_ok = 1'b0;
            end else begin
                dec_address = {dec_address[23:0], dec_value[7:0]};
                dec_index++;
                dec_value = '0;
                dec_started = 1'b0;
            end
        end else begin
            dec_ok = 1'b0;
        end

        nib = nibble_of(c);
        if (hex_closed) begin
            hex_ok = 1'b0;
        end else if (first_char && c == CHAR_LBRACK) begin
            hex_bracketed = 1'b1;
        end else if (nib >= 0) begin
            if (hex_digits >= V6_MAX_DIGITS) begin
                hex_ok = 1'b0;
            end else begin
                hex_groups[hex_index[2:0]] = {hex_groups[hex_index[2:0]][11:0], 4'(nib)};
                hex_digits++;
            end
        end else if (c == CHAR_COLON) begin
            if (hex_index >= V6_GROUPS - 1) begin
                hex_ok = 1'b0;
            end else begin
                hex_index++;
                hex_digits = '0;
            end
        end else if (c == CHAR_RBRACK) begin
            if (hex_bracketed && hex_index == V6_GROUPS - 1) hex_closed = 1'b1;
            else hex_ok = 1'b0;
        end else begin
            hex_ok = 1'b0;
        end
        first_char = 1'b0;

        if (final_char) begin
            r = '0;
            r.ipv6 = !dot_found;
            if (dot_found) begin
                r.addr_ok = dec_ok && dec_index == V4_GROUPS - 1 && dec_started &&
                            dec_value <= V4_MAX;
                if (r.addr_ok) r.lower = {32'd0, dec_address[23:0], dec_value[7:0]};
            end else begin
                r.addr_ok = hex_ok && hex_index == V6_GROUPS - 1 &&
                            (hex_bracketed ? hex_closed : hex_digits != 0);
                if (r.addr_ok) begin
                    r.upper = {hex_groups[0], hex_groups[1], hex_groups[2], hex_groups[3]};
                    r.lower = {hex_groups[4], hex_groups[5], hex_groups[6], hex_groups[7]};
                end
            end
            expected_results.push_back(r);
            clear_parse();
        end
    endtask

    task automatic check_result();
        parse_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with no string pending, tuser=%b tdata=%h",
                                      m_tuser, m_tdata));
        end else begin
            want = expected_results.pop_front();
            if (m_tuser[0] !== want.addr_ok)
                report_mismatch($sformatf("valid_res got %b, want %b", m_tuser[0], want.addr_ok));
            if (m_tuser[1] !== want.ipv6)
                report_mismatch($sformatf("is_ipv6 got %b, want %b", m_tuser[1], want.ipv6));
            if (m_tdata[63:0] !== want.upper)
                report_mismatch($sformatf("address_high got %h, want %h",
                                          m_tdata[63:0], want.upper));
            if (m_tdata[127:64] !== want.lower)
                report_mismatch($sformatf("address_low got %h, want %h",
                                          m_tdata[127:64], want.lower));
            if (!want.addr_ok) bad_count++;
            else if (want.ipv6) v6_count++;
            else v4_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) absorb_char(s_tdata, s_tlast);
        end
        mismatches      <= error_count;
        results_pending <= expected_results.size();
        chars_checked   <= char_count;
        ok_v4           <= v4_count;
        ok_v6           <= v6_count;
        bad_lines       <= bad_count;
    end

endmodule

FILE: dv/tb.sv
// Testbench top for ip_address_text_parser: clock, reset, address strings and verdict.
// Depends on ipp_pkg, the parser RTL and ipp_result_checker, which checks every result.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ipp_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int CHAR_TARGET   = 1350;
    localparam int IDLE_PCT      = 24;
    localparam int SETTLE_CYCLES = 10;

    typedef logic [7:0] char_t;
    typedef enum int {EDIT_DROP, EDIT_INSERT, EDIT_REPLACE, EDIT_CUT, EDIT_APPEND} edit_kind_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [127:0] m_tdata;
    wire  [1:0]   m_tuser;

    int    fails_seen;
    int    results_pending;
    int    chars_checked;
    int    ok_v4;
    int    ok_v6;
    int    bad_lines;

    char_t line_buf[$];
    int    chars_sent = 0;
    int    lines_sent = 0;
    int    stall_cycles = 0;
    logic  steady_run = 1'b0;

    ip_address_text_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ipp_result_checker u_result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (fails_seen),
        .results_pending (results_pending),
        .chars_checked   (chars_checked),
        .ok_v4           (ok_v4),
        .ok_v6           (ok_v6),
        .bad_lines       (bad_lines)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles.", stall_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic char_t pick_junk();
        string marks = ".:[]0 9aFgx+-";
        if ($urandom_range(1)) return char_t'($urandom_range(255));
        return marks[$urandom_range(marks.len() - 1)];
    endfunction

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++) begin
            while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= line_buf[i];
            s_tlast  <= (i == line_buf.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            chars_sent++;
        end
        lines_sent++;
    endtask

    task automatic send_text(input string txt);
        line_buf.delete();
        foreach (txt[k]) line_buf.push_back(txt[k]);
        send_line();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    task automatic add_decimal_group();
        int    roll;
        int    n;
        string digits;
        roll = $urandom_range(99);
        if (roll < 70) begin
            digits = $sformatf("%0d", $urandom_range(255));
        end else if (roll < 80) begin
            digits = $sformatf("%0d", $urandom_range(999, 256));
        end else if (roll < 90) begin
            digits = $sformatf("0%0d", $urandom_range(99));
        end else begin
            digits = "";
            n = $urandom_range(7, 4);
            repeat (n) digits = {digits, $sformatf("%0d", $urandom_range(9))};
        end
        foreach (digits[k]) line_buf.push_back(digits[k]);
    endtask

    task automatic add_hex_group();
        string hexch = "0123456789abcdefABCDEF";
        int    roll;
        int    n;
        roll = $urandom_range(99);
        if (roll < 10) n = 0;
        else if (roll < 92) n = $urandom_range(4, 1);
        else n = $urandom_range(6, 5);
        repeat (n) line_buf.push_back(hexch[$urandom_range(hexch.len() - 1)]);
    endtask

    task automatic build_v4();
        for (int g = 0; g < V4_GROUPS; g++) begin
            add_decimal_group();
            if (g < V4_GROUPS - 1) line_buf.push_back(CHAR_DOT);
        end
    endtask

    task automatic build_v6();
        logic bracketed;
        bracketed = ($urandom_range(99) < 30);
        if (bracketed) line_buf.push_back(CHAR_LBRACK);
        for (int g = 0; g < V6_GROUPS; g++) begin
            add_hex_group();
            if (g < V6_GROUPS - 1) line_buf.push_back(CHAR_COLON);
        end
        if (bracketed) line_buf.push_back(CHAR_RBRACK);
    endtask

    task automatic build_noise();
        int n;
        n = $urandom_range(10, 1);
        repeat (n) line_buf.push_back(pick_junk());
    endtask

    task automatic edit_line();
        edit_kind_t op;
        int         pos;
        op  = edit_kind_t'($urandom_range(EDIT_APPEND));
        pos = $urandom_range(line_buf.size() - 1);
        case (op)
            EDIT_DROP: begin
                if (line_buf.size() > 1) line_buf.delete(pos);
            end
            EDIT_INSERT: begin
                line_buf.insert(pos, pick_junk());
            end
            EDIT_REPLACE: begin
                line_buf[pos] = pick_junk();
            end
            EDIT_CUT: begin
                while (line_buf.size() > pos + 1) void'(line_buf.pop_back());
            end
            default: begin
                line_buf.push_back(pick_junk());
            end
        endcase
    endtask

    initial begin
        string samples[$];
        int    roll;
        int    random_lines;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        samples = '{"0.0.0.0", "255.255.255.255", "256.1.1.1", "1.2.3.4.5", "1..2.3",
                    "1.2.3.4x", "01.002.3.4", "1.2.3", ".1.2.3", "7",
                    "0:0:0:0:0:0:0:0", "ffff:FFFF:aBcD:0:1:2:3:4", "[1::2:3:4:5:6:7]",
                    "1:2:3:4:5:6:7:", "[1:2:3:4:5:6:7:]", "12345:0:0:0:0:0:0:0",
                    "1:2:3:4:5:6:7:8:9", "[1:2:3:4:5:6:7:8]x", "[1:2:3:4:5:6:7:8", "[",
                    " 1.2.3.4", "-1:2:3:4:5:6:7:8", "0x1.2.3.4", "1:2:3:4:5:6:7:8]",
                    "[1.2.3.4]"};
        foreach (samples[k]) send_text(samples[k]);
        line_buf = '{8'h00};
        send_line();
        line_buf = '{8'h31, 8'hFF};
        send_line();
        wait_drained();

        random_lines = 0;
        while (chars_sent < CHAR_TARGET) begin
            line_buf.delete();
            roll = $urandom_range(99);
            if (roll < 42) build_v4();
            else if (roll < 84) build_v6();
            else build_noise();
            if (roll < 84 && $urandom_range(99) < 30) begin
                edit_line();
                if ($urandom_range(1)) edit_line();
            end
            steady_run <= (random_lines >= 20 && random_lines < 32);
            send_line();
            random_lines++;
            if (random_lines % 25 == 0) wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d characters in %0d strings, %0d checked by the predictor.",
                 chars_sent, lines_sent, chars_checked);
        $display("Results: %0d valid IPv4, %0d valid IPv6, %0d rejected; %0d mismatches.",
                 ok_v4, ok_v6, bad_lines, fails_seen);
        if (fails_seen == 0 && results_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
